// File: sv/pwlpd_pkg.sv
// pwlpd_pkg: types, widths and knee table for the pwl pixel decompander
// no dependencies; used by every module of the block

package pwlpd_pkg;

  localparam int IN_W      = 12;
  localparam int OUT_W     = 24;
  localparam int GAIN_FRAC = 24;
  localparam int GAIN_W    = GAIN_FRAC + 1;
  localparam int NUM_W     = IN_W + GAIN_FRAC;
  localparam int NUM_KNEES = 10;
  localparam int SEL_W     = $clog2(NUM_KNEES);

  typedef logic [IN_W-1:0]   code_t;
  typedef logic [OUT_W-1:0]  lin_t;
  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [SEL_W-1:0]  sel_t;

  localparam code_t PEDESTAL_RESET = code_t'(240);
  localparam lin_t  FULL_SCALE     = {OUT_W{1'b1}};

  localparam lin_t KNEE_LIN_X [NUM_KNEES] = '{
    24'h000000, 24'h000180, 24'h000640, 24'h000E74, 24'h005DC0,
    24'h011D28, 24'h033D58, 24'h16E360, 24'h4C4B40, 24'hFFFFFF
  };

  localparam code_t KNEE_COMP_Y [NUM_KNEES] = '{
    12'h000, 12'h180, 12'h315, 12'h3FE, 12'h4FE,
    12'h632, 12'h7E3, 12'h96F, 12'hB87, 12'hF0E
  };

  localparam gain_t KNEE_GAIN [NUM_KNEES] = '{
    25'h1000000, 25'h0555555, 25'h01C71C7, 25'h0033975, 25'h0019CBA,
    25'h000CE5D, 25'h0001419, 25'h0000A0C, 25'h0000506, 25'h0000000
  };

  // word travelling along the divider chain
  typedef struct packed {
    logic  full;
    lin_t  lin_x;
    gain_t gain;
    gain_t rem;
    num_t  nq;
  } div_word_t;

endpackage

// File: sv/pwl_pixel_decompander_unit.sv
// pwl_pixel_decompander_unit: top level, pedestal register, divider chain, output stage
// depends on pwlpd_pkg, pwlpd_knee_sel and pwlpd_div_cell
//
//   channel  | ports                                    | side
//   ---------+------------------------------------------+--------
//   pixel in | in_valid, in_stall, in_pixel_code        | input
//   result   | out_valid, out_stall, out_linear_value   | output
//   config   | cfg_wr_en, cfg_wr_data                   | input
//
// one word accepted per cycle while out_stall does not hold the output; the path runs through
// two front stages, the 36-cell divider chain and the output register
// reset clears all valid flags and loads the pedestal with 240
// a stalled output word freezes the whole chain and raises in_stall

module pwl_pixel_decompander_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [11:0]              in_pixel_code,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [23:0]              out_linear_value,
  input  logic                     cfg_wr_en,
  input  logic [11:0]              cfg_wr_data
);

  localparam int NW = pwlpd_pkg::NUM_W;

  pwlpd_pkg::code_t       pedestal_r;
  logic                   advance;
  logic [NW:0]            valid_c;
  pwlpd_pkg::div_word_t   word_c [NW+1];
  logic                   out_valid_r;
  pwlpd_pkg::lin_t        out_value_r;
  pwlpd_pkg::lin_t        out_value_nxt;
  logic [NW:0]            sum;
  pwlpd_pkg::div_word_t   last_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pedestal_r <= pwlpd_pkg::PEDESTAL_RESET;
    end else if (cfg_wr_en) begin
      pedestal_r <= cfg_wr_data;
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  pwlpd_knee_sel u_knee_sel (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .valid_i    (in_valid),
    .code_i     (in_pixel_code),
    .pedestal_i (pedestal_r),
    .valid_o    (valid_c[0]),
    .word_o     (word_c[0])
  );

  for (genvar g = 0; g < NW; g++) begin : g_cell
    pwlpd_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .valid_i (valid_c[g]),
      .word_i  (word_c[g]),
      .valid_o (valid_c[g+1]),
      .word_o  (word_c[g+1])
    );
  end

  assign last_word = word_c[NW];

  // add knee offset and saturate at full scale
  always_comb begin
    sum = {1'b0, last_word.nq} + (NW+1)'(last_word.lin_x);
    if (last_word.full || (sum > (NW+1)'(pwlpd_pkg::FULL_SCALE))) begin
      out_value_nxt = pwlpd_pkg::FULL_SCALE;
    end else begin
      out_value_nxt = sum[pwlpd_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= valid_c[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_linear_value = out_value_r;

  a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(valid_c))
    else $error("divider chain moved while output stalled");

  a_zero_gain_full: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && valid_c[NW] && last_word.full) |=> (out_value_r == pwlpd_pkg::FULL_SCALE))
    else $error("zero-gain knee did not give full scale");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_c[NW] && (last_word.gain != '0)) |-> (last_word.rem < last_word.gain))
    else $error("division remainder not below divisor");

  a_word_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && valid_c[NW]) |=> out_valid_r)
    else $error("finished word lost at output stage");

endmodule

// File: sv/pwlpd_knee_sel.sv
// pwlpd_knee_sel: pedestal subtraction and knee selection, two register stages
// depends on pwlpd_pkg; feeds the first divider cell

module pwlpd_knee_sel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic                  valid_i,
  input  pwlpd_pkg::code_t      code_i,
  input  pwlpd_pkg::code_t      pedestal_i,
  output logic                  valid_o,
  output pwlpd_pkg::div_word_t  word_o
);

  logic                 valid_a_r;
  pwlpd_pkg::code_t     y_a_r;
  pwlpd_pkg::code_t     y_nxt;
  logic                 valid_b_r;
  pwlpd_pkg::div_word_t word_b_r;
  pwlpd_pkg::div_word_t word_nxt;
  pwlpd_pkg::sel_t      sel;
  logic                 stop;
  pwlpd_pkg::code_t     diff;

  // black pedestal with clamp at zero
  always_comb begin
    if (code_i > pedestal_i) begin
      y_nxt = code_i - pedestal_i;
    end else begin
      y_nxt = '0;
    end
  end

  // last knee of the leading run whose coordinate is not above y
  always_comb begin
    sel  = '0;
    stop = 1'b0;
    for (int i = 1; i < pwlpd_pkg::NUM_KNEES; i++) begin
      if (!stop && (pwlpd_pkg::KNEE_COMP_Y[i] <= y_a_r)) begin
        sel = pwlpd_pkg::sel_t'(i);
      end else begin
        stop = 1'b1;
      end
    end
    diff           = y_a_r - pwlpd_pkg::KNEE_COMP_Y[sel];
    word_nxt.gain  = pwlpd_pkg::KNEE_GAIN[sel];
    word_nxt.lin_x = pwlpd_pkg::KNEE_LIN_X[sel];
    word_nxt.full  = (pwlpd_pkg::KNEE_GAIN[sel] == '0);
    word_nxt.rem   = '0;
    word_nxt.nq    = {diff, {pwlpd_pkg::GAIN_FRAC{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else if (advance) begin
      valid_a_r <= valid_i;
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      y_a_r    <= y_nxt;
      word_b_r <= word_nxt;
    end
  end

  assign valid_o = valid_b_r;
  assign word_o  = word_b_r;

endmodule

// File: sv/pwlpd_div_cell.sv
// pwlpd_div_cell: one restoring division step, one quotient bit per cell
// depends on pwlpd_pkg; chained by the top level

module pwlpd_div_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic                  valid_i,
  input  pwlpd_pkg::div_word_t  word_i,
  output logic                  valid_o,
  output pwlpd_pkg::div_word_t  word_o
);

  logic                        valid_r;
  pwlpd_pkg::div_word_t        word_r;
  pwlpd_pkg::div_word_t        word_nxt;
  logic [pwlpd_pkg::GAIN_W:0]  trial;
  logic [pwlpd_pkg::GAIN_W:0]  diff;
  logic                        ge;

  always_comb begin
    trial    = {word_i.rem, word_i.nq[pwlpd_pkg::NUM_W-1]};
    ge       = (trial >= {1'b0, word_i.gain});
    diff     = trial - {1'b0, word_i.gain};
    word_nxt = word_i;
    if (ge) begin
      word_nxt.rem = diff[pwlpd_pkg::GAIN_W-1:0];
    end else begin
      word_nxt.rem = trial[pwlpd_pkg::GAIN_W-1:0];
    end
    word_nxt.nq = {word_i.nq[pwlpd_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

// File: tb/sv/tb_pwl_pixel_decompander_unit.sv
// tb_pwl_pixel_decompander_unit: self-checking bench for the pwl pixel decompander
// predicts each linear word from its own knee table and pedestal copy, under random idling in most phases
// depends on pwlpd_pkg and pwl_pixel_decompander_unit

module tb_pwl_pixel_decompander_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               KNEES        = 10;
  localparam int               GAIN_SHIFT   = 24;
  localparam int               QUIET_LIMIT  = 2000;
  localparam int               SETTLE       = 45;
  localparam pwlpd_pkg::code_t PED_AT_RESET = 12'd240;
  localparam pwlpd_pkg::lin_t  LIN_MAX      = 24'hFFFFFF;

  localparam pwlpd_pkg::lin_t  KX [KNEES] = '{
    24'h000000, 24'h000180, 24'h000640, 24'h000E74, 24'h005DC0,
    24'h011D28, 24'h033D58, 24'h16E360, 24'h4C4B40, 24'hFFFFFF
  };
  localparam pwlpd_pkg::code_t KY [KNEES] = '{
    12'h000, 12'h180, 12'h315, 12'h3FE, 12'h4FE,
    12'h632, 12'h7E3, 12'h96F, 12'hB87, 12'hF0E
  };
  localparam pwlpd_pkg::gain_t KG [KNEES] = '{
    25'h1000000, 25'h0555555, 25'h01C71C7, 25'h0033975, 25'h0019CBA,
    25'h000CE5D, 25'h0001419, 25'h0000A0C, 25'h0000506, 25'h0000000
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_pixel_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_linear_value;
  logic        cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = '0;

  pwlpd_pkg::code_t code_q [$];
  pwlpd_pkg::lin_t  lin_due_q [$];
  pwlpd_pkg::code_t ped_model = PED_AT_RESET;
  bit    in_taken = 1'b0;
  bit    out_taken = 1'b0;
  bit    idle_on = 1'b0;
  int    gap_left = 0;
  int    stall_left = 0;
  int    quiet_cycles = 0;
  int    errors = 0;

  pwl_pixel_decompander_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_code    (in_pixel_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_linear_value (out_linear_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic pwlpd_pkg::lin_t decompand_code(pwlpd_pkg::code_t code,
                                                     pwlpd_pkg::code_t ped);
    pwlpd_pkg::code_t y;
    int               sel;
    logic [63:0]      q;
    y = (code > ped) ? code - ped : '0;
    sel = 0;
    for (int i = 1; i < KNEES; i++) begin
      if (KY[i] <= y) sel = i;
    end
    if (KG[sel] == '0) return LIN_MAX;
    q = (64'(y - KY[sel]) << GAIN_SHIFT) / 64'(KG[sel]) + 64'(KX[sel]);
    return (q > 64'(LIN_MAX)) ? LIN_MAX : q[23:0];
  endfunction

  function automatic pwlpd_pkg::code_t clamp_code(int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'hFFF;
    return pwlpd_pkg::code_t'(v);
  endfunction

  function automatic pwlpd_pkg::code_t rand_code(pwlpd_pkg::code_t ped);
    int k;
    case ($urandom_range(0, 3)) inside
      [0:1]: return pwlpd_pkg::code_t'($urandom_range(0, 4095));
      2: begin
        k = $urandom_range(0, KNEES - 1);
        return clamp_code(int'(ped) + int'(KY[k]) + int'($urandom_range(0, 8)) - 4);
      end
      default: return clamp_code(int'($urandom_range(0, int'(ped) + 8)));
    endcase
  endfunction

  // pixel driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (idle_on && code_q.size() > 0 && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (code_q.size() > 0) begin
        in_valid <= 1'b1;
        in_pixel_code <= code_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin : check_words
    pwlpd_pkg::lin_t want;
    if (!rst_n) begin
      ped_model = PED_AT_RESET;
      in_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      if (cfg_wr_en) ped_model = cfg_wr_data;
      if (in_taken) lin_due_q.push_back(decompand_code(in_pixel_code, ped_model));
      if (out_taken) begin
        if (lin_due_q.size() == 0) begin
          $error("linear_value: expected none, actual %0h", out_linear_value);
          errors++;
        end else begin
          want = lin_due_q.pop_front();
          if (out_linear_value !== want) begin
            $error("linear_value: expected %0h, actual %0h", want, out_linear_value);
            errors++;
          end
        end
      end
      quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_pwl_pixel_decompander_unit: done, errors");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (code_q.size() != 0 || in_valid || lin_due_q.size() != 0);
  endtask

  task automatic set_pedestal(pwlpd_pkg::code_t v);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(pwlpd_pkg::code_t ped, int n_rand, bit idle);
    idle_on = idle;
    code_q.push_back('0);
    code_q.push_back(12'hFFF);
    for (int k = 0; k < KNEES; k++) begin
      code_q.push_back(clamp_code(int'(ped) + int'(KY[k]) - 1));
      code_q.push_back(clamp_code(int'(ped) + int'(KY[k])));
    end
    code_q.push_back(clamp_code(int'(ped) + 1));
    for (int i = 0; i < n_rand / 2; i++) code_q.push_back(rand_code(ped));
    // sender holds off until the pipe has emptied
    wait_drained();
    for (int i = n_rand / 2; i < n_rand; i++) code_q.push_back(rand_code(ped));
    wait_drained();
  endtask

  initial begin : stimulus
    pwlpd_pkg::code_t ped;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    run_phase(PED_AT_RESET, 300, 1'b1);
    set_pedestal('0);
    run_phase('0, 400, 1'b1);
    set_pedestal(12'hFFF);
    run_phase(12'hFFF, 100, 1'b1);
    repeat (4) begin
      ped = pwlpd_pkg::code_t'($urandom_range(0, 1023));
      set_pedestal(ped);
      run_phase(ped, 200, $urandom_range(0, 3) != 0);
    end
    set_pedestal(PED_AT_RESET);
    run_phase(PED_AT_RESET, 300, 1'b0);
    repeat (60) @(negedge clk);
    if (errors == 0) begin
      $display("tb_pwl_pixel_decompander_unit: done, clean");
    end else begin
      $display("tb_pwl_pixel_decompander_unit: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/pwlpd_pkg.sv
sv/pwlpd_knee_sel.sv
sv/pwlpd_div_cell.sv
sv/pwl_pixel_decompander_unit.sv
tb/sv/tb_pwl_pixel_decompander_unit.sv
